// ===== rtl/core/clni_pkg.sv =====
// Package for the character LCD 4-bit nibble interface.
// Holds the request and pulse transaction types, mode codes, command bytes,
// the init pulse table and the pulse selection function. No dependencies.
`default_nettype none

package clni_pkg;

  // Request modes
  typedef enum logic [2:0] {
    MODE_DATA  = 3'd0,
    MODE_CMD   = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_HOME  = 3'd3,
    MODE_GOTO  = 3'd4,
    MODE_INIT  = 3'd5
  } mode_e;

  // Input transaction: one request
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] value;
    logic [1:0] row;
    logic [4:0] col;
  } lcd_req_t;

  // Output transaction: one enable pulse
  typedef struct packed {
    logic [5:0] wait_before_ms;
    logic [3:0] nibble;
    logic       reg_select;
    logic [2:0] wait_after_ms;
    logic       last;
  } lcd_pulse_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic req_ok;
    logic pulse_last;
  } dp_sts_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_e;

  // Command bytes and waits
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [7:0] CMD_GOTO  = 8'h80;
  localparam logic [7:0] GOTO_ROW2 = 8'h40;
  localparam logic [2:0] WAIT_BYTE = 3'd1;
  localparam logic [2:0] WAIT_LONG = 3'd3;

  // Init pulse sequence: soft reset nibbles, then 0x28, 0x06, 0x0E, clear
  localparam int INIT_LEN = 12;

  typedef struct packed {
    logic [5:0] lead;
    logic [3:0] nibble;
    logic [2:0] after;
  } init_entry_t;

  localparam init_entry_t INIT_SEQ [INIT_LEN] = '{
    '{6'd50, 4'h3, 3'd5},
    '{6'd0,  4'h3, 3'd1},
    '{6'd0,  4'h3, 3'd5},
    '{6'd0,  4'h2, 3'd5},
    '{6'd0,  4'h2, 3'd0},
    '{6'd0,  4'h8, 3'd1},
    '{6'd0,  4'h0, 3'd0},
    '{6'd0,  4'h6, 3'd1},
    '{6'd0,  4'h0, 3'd0},
    '{6'd0,  4'hE, 3'd1},
    '{6'd0,  4'h0, 3'd0},
    '{6'd0,  4'h1, 3'd3}
  };

  // Select the pulse at a given step of a request
  function automatic lcd_pulse_t pulse_at(logic init, logic [7:0] cmd_byte, logic rs,
                                          logic [2:0] lo_wait, logic [3:0] step);
    lcd_pulse_t p;
    p = '0;
    if (init) begin
      if (step < 4'(INIT_LEN)) begin
        p.wait_before_ms = INIT_SEQ[step].lead;
        p.nibble         = INIT_SEQ[step].nibble;
        p.wait_after_ms  = INIT_SEQ[step].after;
      end
      p.reg_select = 1'b0;
      p.last       = (step == 4'(INIT_LEN - 1));
    end else begin
      p.reg_select = rs;
      if (step == 4'd0) begin
        p.nibble = cmd_byte[7:4];
      end else begin
        p.nibble        = cmd_byte[3:0];
        p.wait_after_ms = lo_wait;
        p.last          = 1'b1;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clni_dpath.sv =====
// Datapath of the character LCD nibble interface.
// Decodes a request, holds it with a step counter and the output pulse register.
// Depends on clni_pkg.
`default_nettype none

module clni_dpath
  import clni_pkg::*;
(
  input  wire        clk_i,
  input  lcd_req_t   req_i,
  input  dp_cmd_t    cmd_i,
  output dp_sts_t    sts_o,
  output lcd_pulse_t pulse_o
);

  logic       dec_ok;
  logic       dec_init;
  logic [7:0] dec_byte;
  logic       dec_rs;
  logic [2:0] dec_wait;
  logic [3:0] col_m1;

  logic       init_q,  init_d;
  logic [7:0] byte_q,  byte_d;
  logic       rs_q,    rs_d;
  logic [2:0] wait_q,  wait_d;
  logic [3:0] step_q,  step_d;
  lcd_pulse_t pulse_q, pulse_d;

  // Decode the incoming request into a command byte and its waits
  assign col_m1 = req_i.col[3:0] - 4'd1;

  always_comb begin
    dec_ok   = 1'b1;
    dec_init = 1'b0;
    dec_byte = req_i.value;
    dec_rs   = 1'b0;
    dec_wait = WAIT_BYTE;
    case (req_i.mode)
      MODE_DATA: begin
        dec_rs = 1'b1;
      end
      MODE_CMD: begin
        dec_rs = 1'b0;
      end
      MODE_CLEAR: begin
        dec_byte = CMD_CLEAR;
        dec_wait = WAIT_LONG;
      end
      MODE_HOME: begin
        dec_byte = CMD_HOME;
        dec_wait = WAIT_LONG;
      end
      MODE_GOTO: begin
        dec_byte = CMD_GOTO | (~req_i.row[0] ? GOTO_ROW2 : 8'h00) | {4'h0, col_m1};
      end
      MODE_INIT: begin
        dec_init = 1'b1;
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  // Load a new request or advance to the next pulse
  always_comb begin
    init_d  = init_q;
    byte_d  = byte_q;
    rs_d    = rs_q;
    wait_d  = wait_q;
    step_d  = step_q;
    pulse_d = pulse_q;
    if (cmd_i.load) begin
      init_d  = dec_init;
      byte_d  = dec_byte;
      rs_d    = dec_rs;
      wait_d  = dec_wait;
      step_d  = 4'd0;
      pulse_d = pulse_at(dec_init, dec_byte, dec_rs, dec_wait, 4'd0);
    end else if (cmd_i.advance) begin
      step_d  = step_q + 4'd1;
      pulse_d = pulse_at(init_q, byte_q, rs_q, wait_q, step_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    init_q  <= init_d;
    byte_q  <= byte_d;
    rs_q    <= rs_d;
    wait_q  <= wait_d;
    step_q  <= step_d;
    pulse_q <= pulse_d;
  end

  assign sts_o.req_ok     = dec_ok;
  assign sts_o.pulse_last = pulse_q.last;
  assign pulse_o          = pulse_q;

endmodule

`default_nettype wire

// ===== rtl/core/clni_ctrl.sv =====
// Controller of the character LCD nibble interface.
// Runs the request/pulse handshakes and steers the datapath. Depends on clni_pkg.
`default_nettype none

module clni_ctrl
  import clni_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  wire     out_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && sts_i.req_ok) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.pulse_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Never take a request while a pulse is offered
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o))
    else $error("request taken while a pulse is pending");

  // Drop the output after the final pulse is taken
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && sts_i.pulse_last) |=> !out_valid_o)
    else $error("output still valid after final pulse");

  // Keep the output up after a pulse that is not the last
  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !sts_i.pulse_last) |=> out_valid_o)
    else $error("request ended before its final pulse");

  // Load only from idle and start emitting next
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_o && !cmd_o.advance) ##1 out_valid_o)
    else $error("load outside idle or not followed by a pulse");

endmodule

`default_nettype wire

// ===== rtl/core/char_lcd_nibble_interface.sv =====
// Top level of the character LCD 4-bit nibble interface.
// Joins the controller (clni_ctrl) and the datapath (clni_dpath); uses clni_pkg.
//
//   channel  direction  handshake                 transaction
//   in       input      in_valid_i / in_stall_o   lcd_req_t (one request)
//   out      output     out_valid_o / out_stall_i lcd_pulse_t (one enable pulse)
//
// A request is taken only when no pulse is pending; its first pulse is shown
// the next cycle and each further pulse in the cycle after the previous is taken.
// A request costs 2 pulses (12 for init) plus a return to idle; modes 6 and 7
// are taken and give no pulse. The step counter of the datapath selects each pulse.
// Reset clears the controller to idle; out_stall_i holds the current pulse.
`default_nettype none

module char_lcd_nibble_interface
  import clni_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  lcd_req_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output lcd_pulse_t out_data_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequence the handshakes
  clni_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // Decode and step through pulses
  clni_dpath u_dpath (
    .clk_i   (clk_i),
    .req_i   (in_data_i),
    .cmd_i   (dp_cmd),
    .sts_o   (dp_sts),
    .pulse_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for char_lcd_nibble_interface.
// It predicts the enable-pulse transactions for each accepted request and checks them in order.
// It varies the valid/stall pressure on both channels. Depends on clni_pkg and the block's RTL.
`default_nettype none

module tb
  import clni_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 16;

  // Track expected enable pulses and compare accepted ones
  class pulse_scoreboard;
    lcd_pulse_t pending[$];
    int errors;
    int requests;
    int silent_requests;
    int pulses;

    function new();
      errors          = 0;
      requests        = 0;
      silent_requests = 0;
      pulses          = 0;
    endfunction

    function void add_pulse(logic [5:0] lead, logic [3:0] nib, logic rs,
                            logic [2:0] after);
      lcd_pulse_t p;
      p.wait_before_ms = lead;
      p.nibble         = nib;
      p.reg_select     = rs;
      p.wait_after_ms  = after;
      p.last           = 1'b0;
      pending.push_back(p);
    endfunction

    // High nibble first, then low nibble with the settle wait
    function void add_byte(logic [7:0] b, logic rs, logic [2:0] lo_wait);
      add_pulse(6'd0, b[7:4], rs, 3'd0);
      add_pulse(6'd0, b[3:0], rs, lo_wait);
    endfunction

    // Expand one accepted request into its pulse sequence
    function void note_request(lcd_req_t r);
      int         start;
      logic [1:0] row_m1;
      logic [4:0] col_m1;
      logic [7:0] addr_cmd;
      start = pending.size();
      requests++;
      case (r.mode)
        MODE_DATA:  add_byte(r.value, 1'b1, WAIT_BYTE);
        MODE_CMD:   add_byte(r.value, 1'b0, WAIT_BYTE);
        MODE_CLEAR: add_byte(CMD_CLEAR, 1'b0, WAIT_LONG);
        MODE_HOME:  add_byte(CMD_HOME, 1'b0, WAIT_LONG);
        MODE_GOTO: begin
          // Wrap one-based row and column: row 0 maps to line 2, column 0 to 16
          row_m1   = r.row - 2'd1;
          col_m1   = r.col - 5'd1;
          addr_cmd = CMD_GOTO | (row_m1[0] ? GOTO_ROW2 : 8'h00) | {4'h0, col_m1[3:0]};
          add_byte(addr_cmd, 1'b0, WAIT_BYTE);
        end
        MODE_INIT: begin
          // Soft reset nibbles, then function set, entry mode, display on, clear
          add_pulse(6'd50, 4'h3, 1'b0, 3'd5);
          add_pulse(6'd0,  4'h3, 1'b0, 3'd1);
          add_pulse(6'd0,  4'h3, 1'b0, 3'd5);
          add_pulse(6'd0,  4'h2, 1'b0, 3'd5);
          add_byte(8'h28, 1'b0, WAIT_BYTE);
          add_byte(8'h06, 1'b0, WAIT_BYTE);
          add_byte(8'h0E, 1'b0, WAIT_BYTE);
          add_byte(CMD_CLEAR, 1'b0, WAIT_LONG);
        end
        default: silent_requests++;
      endcase
      if (pending.size() > start) begin
        pending[pending.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_pulse(lcd_pulse_t got);
      lcd_pulse_t exp;
      pulses++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected pulse before=%0d nibble=%h rs=%b after=%0d last=%b",
                 $time, got.wait_before_ms, got.nibble, got.reg_select,
                 got.wait_after_ms, got.last);
        return;
      end
      exp = pending.pop_front();
      if (got.wait_before_ms !== exp.wait_before_ms || got.nibble !== exp.nibble ||
          got.reg_select !== exp.reg_select || got.wait_after_ms !== exp.wait_after_ms ||
          got.last !== exp.last) begin
        errors++;
        $display("%0t: pulse mismatch expected before=%0d nibble=%h rs=%b after=%0d last=%b",
                 $time, exp.wait_before_ms, exp.nibble, exp.reg_select,
                 exp.wait_after_ms, exp.last);
        $display("%0t:                actual before=%0d nibble=%h rs=%b after=%0d last=%b",
                 $time, got.wait_before_ms, got.nibble, got.reg_select,
                 got.wait_after_ms, got.last);
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  lcd_req_t   in_data     = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  lcd_pulse_t out_data;

  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  pulse_scoreboard sb;

  char_lcd_nibble_interface u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply random backpressure on the pulse channel
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Record accepted transactions on both channels; request first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_pulse(out_data);
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d pulses outstanding", $time,
                 sb.pending.size());
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one request, with an optional random gap, and hold it until taken
  task automatic send_request(input logic [2:0] mode, input logic [7:0] value,
                              input logic [1:0] row, input logic [4:0] col);
    lcd_req_t r;
    r.mode  = mode;
    r.value = value;
    r.row   = row;
    r.col   = col;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Mostly well-formed requests; a few unused modes and out-of-range positions
  task automatic send_random(input int count);
    int         pick;
    logic [2:0] mode;
    logic [1:0] row;
    logic [4:0] col;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        mode = 3'($urandom_range(6, 7));
      end else if (pick < 14) begin
        mode = MODE_INIT;
      end else begin
        mode = 3'($urandom_range(0, 4));
      end
      if ($urandom_range(0, 9) == 0) begin
        row = 2'($urandom);
        col = 5'($urandom);
      end else begin
        row = 2'($urandom_range(1, 2));
        col = 5'($urandom_range(1, 16));
      end
      send_request(mode, 8'($urandom), row, col);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: byte extremes, every mode, wrapped goto positions, unused modes
    send_request(MODE_DATA,  8'h00, 2'd1, 5'd1);
    send_request(MODE_DATA,  8'hFF, 2'd1, 5'd1);
    send_request(MODE_DATA,  8'h5A, 2'd2, 5'd16);
    send_request(MODE_CMD,   8'h00, 2'd1, 5'd1);
    send_request(MODE_CMD,   8'hFF, 2'd2, 5'd16);
    send_request(MODE_CMD,   8'hA5, 2'd1, 5'd1);
    send_request(MODE_CLEAR, 8'hFF, 2'd3, 5'd31);
    send_request(MODE_HOME,  8'h00, 2'd0, 5'd0);
    send_request(MODE_GOTO,  8'h00, 2'd1, 5'd1);
    send_request(MODE_GOTO,  8'h00, 2'd2, 5'd16);
    send_request(MODE_GOTO,  8'hFF, 2'd1, 5'd16);
    send_request(MODE_GOTO,  8'h00, 2'd2, 5'd1);
    send_request(MODE_GOTO,  8'h00, 2'd0, 5'd0);
    send_request(MODE_GOTO,  8'h00, 2'd3, 5'd31);
    send_request(MODE_GOTO,  8'h00, 2'd2, 5'd17);
    send_request(MODE_INIT,  8'h00, 2'd1, 5'd1);
    send_request(3'd6,       8'hFF, 2'd3, 5'd31);
    send_request(3'd7,       8'h00, 2'd0, 5'd0);
    send_request(MODE_DATA,  8'h41, 2'd1, 5'd1);
    send_request(MODE_INIT,  8'hFF, 2'd3, 5'd31);

    // Random traffic across the pressure phases
    send_random(115);
    idle_pct = 85;
    send_random(115);
    idle_pct  = 0;
    stall_pct = 85;
    send_random(115);
    idle_pct  = 22;
    stall_pct = 22;
    send_random(115);
    in_valid <= 1'b0;

    // Drain outstanding pulses, then let trailing work settle
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests (%0d in unused modes) and checked %0d pulses",
             sb.requests, sb.silent_requests, sb.pulses);
    $display("Phases: no pressure, sparse requests, heavy stall, mixed pressure");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0t: %0d mismatches, %0d pulses never seen", $time, sb.errors,
               sb.pending.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/clni_pkg.sv
rtl/core/clni_dpath.sv
rtl/core/clni_ctrl.sv
rtl/core/char_lcd_nibble_interface.sv
bench/tb.sv
